// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/cfta_pkg.sv
// ---------------------------------------------------------------------------
// cfta_pkg
// types, constants and the hex digit converter of the can frame text encoder
// ---------------------------------------------------------------------------
package cfta_pkg;

  localparam logic [3:0] MAX_DATA_BYTES = 4'd8;

  // register indexes on the configuration port
  localparam logic REG_CANSEND_FORMAT   = 1'b0;
  localparam logic REG_EXTRA_LINE_FEED  = 1'b1;

  // fixed characters
  localparam logic [7:0] CHAR_HASH   = 8'h23;
  localparam logic [7:0] CHAR_UP_R   = 8'h52;
  localparam logic [7:0] CHAR_UP_T   = 8'h54;
  localparam logic [7:0] CHAR_LO_R   = 8'h72;
  localparam logic [7:0] CHAR_LO_T   = 8'h74;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_UP_A   = 8'h41;

  // sequencer states, idle plus one per field of the text line
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREFIX,
    ST_ID,
    ST_HASH,
    ST_RCHAR,
    ST_LEN,
    ST_DATA,
    ST_CR,
    ST_LF
  } state_t;

  // uppercase hex digit of one nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CHAR_ZERO + {4'd0, nib};
    end else begin
      c = CHAR_UP_A + {4'd0, nib - 4'd10};
    end
    return c;
  endfunction

endpackage

// File: rtl/core/can_frame_to_ascii_text.sv
// ---------------------------------------------------------------------------
// can_frame_to_ascii_text
// turns one received can frame into a line of ascii text, one char per item
// ---------------------------------------------------------------------------
// One frame is taken on the slave side, then the block is busy until the
// whole line has been handed to the output register. A line is N characters:
// slcan gives 1 + 3/8 id digits + 1 length digit + 2 per data byte (none for
// remote frames), cansend gives 3/8 id digits + '#' + either 'R' (and the
// length digit when the length is nonzero) or 2 per data byte; both add CR
// and, when enabled, LF. N is at most 28. The sequencer walks the fields one
// character at a time through a single nibble-to-hex converter, one character
// a cycle while the output register is free. The next frame can be taken
// while the final character still waits in the output register.
// Configuration writes are always taken and must only be made while the
// block is idle.
// ---------------------------------------------------------------------------
module can_frame_to_ascii_text (
  input  logic         clk,
  input  logic         rst,
  // configuration write channel
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic         cfg_data,
  // frame input
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: frame_id[28:0], data_length[32:29], byte0[40:33] .. byte7[96:89],
  //        zero pad [103:97]
  input  logic [103:0] s_axis_tdata,
  // tuser: is_extended[0], is_remote[1]
  input  logic [1:0]   s_axis_tuser,
  // text output
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: text_char[7:0]
  output logic [7:0]   m_axis_tdata,
  output logic         m_axis_tlast
);

  // configuration registers
  logic cansend_format;
  logic extra_line_feed;

  // held frame
  logic        held_ext;
  logic        held_rem;
  logic [3:0]  held_len;
  logic [31:0] id_sr;       // id digits, most significant nibble at the top
  logic [63:0] data_sr;     // data bytes, byte0 in the low bits
  logic        lo_nib;      // next data digit is the low nibble
  logic [4:0]  cnt;         // digits left in the current field

  cfta_pkg::state_t state, state_next;
  logic [31:0] id_sr_next;
  logic [63:0] data_sr_next;
  logic        lo_nib_next;
  logic [4:0]  cnt_next;

  logic        out_load;
  logic [7:0]  out_char;
  logic        out_last;
  logic [3:0]  hex_nib;     // operand of the shared hex converter
  logic [7:0]  hex_out;

  logic        s_accept;
  logic        step;
  logic [3:0]  in_len;
  logic [3:0]  in_len_sat;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == cfta_pkg::ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  // output register free this cycle
  assign step          = !m_axis_tvalid || m_axis_tready;

  assign in_len     = s_axis_tdata[32:29];
  assign in_len_sat = (in_len > cfta_pkg::MAX_DATA_BYTES) ? cfta_pkg::MAX_DATA_BYTES : in_len;

  assign hex_out = cfta_pkg::hex_char(hex_nib);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cansend_format  <= 1'b0;
      extra_line_feed <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cfta_pkg::REG_CANSEND_FORMAT:  cansend_format  <= cfg_data;
        cfta_pkg::REG_EXTRA_LINE_FEED: extra_line_feed <= cfg_data;
        default: ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfta_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // frame hold and field walkers
  always_ff @(posedge clk) begin
    if (s_accept) begin
      held_ext <= s_axis_tuser[0];
      held_rem <= s_axis_tuser[1];
      held_len <= in_len_sat;
      // standard ids keep the low 11 bits as three digits
      if (s_axis_tuser[0]) begin
        id_sr <= {3'd0, s_axis_tdata[28:0]};
      end else begin
        id_sr <= {1'b0, s_axis_tdata[10:0], 20'd0};
      end
      data_sr <= s_axis_tdata[96:33];
      lo_nib  <= 1'b0;
    end else begin
      id_sr   <= id_sr_next;
      data_sr <= data_sr_next;
      lo_nib  <= lo_nib_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 5'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // sequencer: next state and the character of this cycle
  always_comb begin
    state_next   = state;
    id_sr_next   = id_sr;
    data_sr_next = data_sr;
    lo_nib_next  = lo_nib;
    cnt_next     = cnt;
    out_load     = 1'b0;
    out_char     = cfta_pkg::CHAR_CR;
    out_last     = 1'b0;
    hex_nib      = held_len;

    unique case (state)
      cfta_pkg::ST_IDLE: begin
        if (s_accept) begin
          cnt_next   = s_axis_tuser[0] ? 5'd8 : 5'd3;
          state_next = cansend_format ? cfta_pkg::ST_ID : cfta_pkg::ST_PREFIX;
        end
      end
      cfta_pkg::ST_PREFIX: begin
        if (held_ext) begin
          out_char = held_rem ? cfta_pkg::CHAR_UP_R : cfta_pkg::CHAR_UP_T;
        end else begin
          out_char = held_rem ? cfta_pkg::CHAR_LO_R : cfta_pkg::CHAR_LO_T;
        end
        if (step) begin
          out_load   = 1'b1;
          state_next = cfta_pkg::ST_ID;
        end
      end
      cfta_pkg::ST_ID: begin
        hex_nib  = id_sr[31:28];
        out_char = hex_out;
        if (step) begin
          out_load   = 1'b1;
          id_sr_next = {id_sr[27:0], 4'd0};
          cnt_next   = cnt - 5'd1;
          if (cnt == 5'd1) begin
            state_next = cansend_format ? cfta_pkg::ST_HASH : cfta_pkg::ST_LEN;
          end
        end
      end
      cfta_pkg::ST_HASH: begin
        out_char = cfta_pkg::CHAR_HASH;
        if (step) begin
          out_load = 1'b1;
          cnt_next = {held_len, 1'b0};
          priority if (held_rem) begin
            state_next = cfta_pkg::ST_RCHAR;
          end else if (held_len != 4'd0) begin
            state_next = cfta_pkg::ST_DATA;
          end else begin
            state_next = cfta_pkg::ST_CR;
          end
        end
      end
      cfta_pkg::ST_RCHAR: begin
        out_char = cfta_pkg::CHAR_UP_R;
        if (step) begin
          out_load   = 1'b1;
          state_next = (held_len != 4'd0) ? cfta_pkg::ST_LEN : cfta_pkg::ST_CR;
        end
      end
      cfta_pkg::ST_LEN: begin
        hex_nib  = held_len;
        out_char = hex_out;
        if (step) begin
          out_load = 1'b1;
          cnt_next = {held_len, 1'b0};
          if (cansend_format || held_rem || held_len == 4'd0) begin
            state_next = cfta_pkg::ST_CR;
          end else begin
            state_next = cfta_pkg::ST_DATA;
          end
        end
      end
      cfta_pkg::ST_DATA: begin
        // high nibble of each byte first
        hex_nib  = lo_nib ? data_sr[3:0] : data_sr[7:4];
        out_char = hex_out;
        if (step) begin
          out_load    = 1'b1;
          lo_nib_next = !lo_nib;
          if (lo_nib) begin
            data_sr_next = {8'd0, data_sr[63:8]};
          end
          cnt_next = cnt - 5'd1;
          if (cnt == 5'd1) begin
            state_next = cfta_pkg::ST_CR;
          end
        end
      end
      cfta_pkg::ST_CR: begin
        out_char = cfta_pkg::CHAR_CR;
        out_last = !extra_line_feed;
        if (step) begin
          out_load   = 1'b1;
          state_next = extra_line_feed ? cfta_pkg::ST_LF : cfta_pkg::ST_IDLE;
        end
      end
      cfta_pkg::ST_LF: begin
        out_char = cfta_pkg::CHAR_LF;
        out_last = 1'b1;
        if (step) begin
          out_load   = 1'b1;
          state_next = cfta_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cfta_pkg::ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= out_char;
      m_axis_tlast <= out_last;
    end
  end

endmodule

// File: rtl/core/cfta_checker.sv
// ---------------------------------------------------------------------------
// cfta_checker
// port level checks of the can frame text encoder, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cfta_checker (
  input logic         clk,
  input logic         rst,
  input logic         cfg_ready,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [7:0]   m_axis_tdata,
  input logic         m_axis_tlast
);

  logic s_acc;

  assign s_acc = s_axis_tvalid && s_axis_tready;

  // a stalled item holds
  `ASSERT_CLK(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)), "output item changed while stalled")

  // a frame in work blocks the input
  `ASSERT_CLK(a_busy_after_accept, s_acc |=> !s_axis_tready, "input ready right after a frame was taken")

  // the input frees up only once the last char of the line is in the output register
  `ASSERT_CLK(a_free_at_last, $rose(s_axis_tready) |-> (m_axis_tvalid && m_axis_tlast), "ready back before the last char was produced")

  // while idle, only a final char may be pending
  `ASSERT_CLK(a_idle_pending_last, (s_axis_tready && m_axis_tvalid) |-> m_axis_tlast, "idle with a char of an open line pending")

  // configuration writes are never held off
  `ASSERT_ALWAYS(a_cfg_ready, cfg_ready, "configuration write held off")

endmodule

bind can_frame_to_ascii_text cfta_checker u_cfta_checker (.*);
